### hw/rtl/wpi_pkg.sv
// Shared constants, types and codes of the waypoint pose interpolator.
// Depends on nothing; the controller, the datapath and the top level refer to it by scoped names.
package wpi_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Alpha is Q0.16 with 1.0 held as 2^16, so the quotient has 17 bits.
  localparam int ALPHA_W   = 17;
  localparam int DIV_CNT_W = $clog2(ALPHA_W + 1);

  localparam int NUM_AXES = 3;
  localparam int AX_W     = $clog2(NUM_AXES);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } wpi_action_e;

  typedef enum logic [1:0] {
    RD_SEG0,
    RD_SEG1,
    RD_LAST
  } wpi_rdsel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_ADD,
    ST_RDLAST,
    ST_TAKE,
    ST_EMIT
  } wpi_state_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } wpi_point_t;

  typedef struct packed {
    logic       pose_valid;
    wpi_point_t point;
  } wpi_res_t;

  typedef struct packed {
    logic       load;
    logic       query_start;
    logic       res_zero;
    logic       scan_run;
    logic       div_step;
    logic       pt_rd_en;
    wpi_rdsel_e pt_rd_sel;
    logic       latch_p0;
    logic       mul;
    logic       add;
    logic       take_last;
    logic       emit;
  } wpi_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic hit;
    logic miss;
    logic div_done;
    logic ax_last;
    logic out_free;
  } wpi_sts_t;

endpackage

### hw/rtl/wpi_in_if.sv
// Input channel of the waypoint pose interpolator: valid, ready and one item.
// Stands alone; the top level takes its sink modport.
interface wpi_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic               first_point;
  logic        [31:0] time_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (
    output valid, action, first_point, time_value,
    output pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
    input  ready
  );

  modport sink (
    input  valid, action, first_point, time_value,
    input  pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

### hw/rtl/wpi_out_if.sv
// Result channel of the waypoint pose interpolator: valid, ready and one pose.
// Stands alone; the top level takes its source modport.
interface wpi_out_if;
  logic               valid;
  logic               ready;
  logic               pose_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [15:0] out_qw;
  logic signed [15:0] out_qx;
  logic signed [15:0] out_qy;
  logic signed [15:0] out_qz;

  modport source (
    output valid, pose_valid, out_x, out_y, out_z,
    output out_qw, out_qx, out_qy, out_qz,
    input  ready
  );

  modport sink (
    input  valid, pose_valid, out_x, out_y, out_z,
    input  out_qw, out_qx, out_qy, out_qz,
    output ready
  );
endinterface

### hw/rtl/wpi_ctrl.sv
// Sequencing state machine of the waypoint pose interpolator.
// Depends on wpi_pkg for the state, command and status types.
module wpi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  wpi_pkg::wpi_action_e in_action_i,
  output logic                 in_ready_o,
  input  wpi_pkg::wpi_sts_t    sts_i,
  output wpi_pkg::wpi_cmd_t    cmd_o
);

  wpi_pkg::wpi_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wpi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == wpi_pkg::ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.query_start = 1'b1;
            if (sts_i.count_zero) begin
              cmd_o.res_zero = 1'b1;
              state_d        = wpi_pkg::ST_EMIT;
            end else begin
              state_d = wpi_pkg::ST_SCAN;
            end
          end
        end
      end
      wpi_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          state_d = wpi_pkg::ST_DIV;
        end else if (sts_i.miss) begin
          state_d = wpi_pkg::ST_RDLAST;
        end
      end
      wpi_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = wpi_pkg::ST_RD0;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      wpi_pkg::ST_RD0: begin
        cmd_o.pt_rd_en  = 1'b1;
        cmd_o.pt_rd_sel = wpi_pkg::RD_SEG0;
        state_d         = wpi_pkg::ST_RD1;
      end
      wpi_pkg::ST_RD1: begin
        cmd_o.latch_p0  = 1'b1;
        cmd_o.pt_rd_en  = 1'b1;
        cmd_o.pt_rd_sel = wpi_pkg::RD_SEG1;
        state_d         = wpi_pkg::ST_MUL;
      end
      wpi_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = wpi_pkg::ST_ADD;
      end
      wpi_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = sts_i.ax_last ? wpi_pkg::ST_EMIT : wpi_pkg::ST_MUL;
      end
      wpi_pkg::ST_RDLAST: begin
        cmd_o.pt_rd_en  = 1'b1;
        cmd_o.pt_rd_sel = wpi_pkg::RD_LAST;
        state_d         = wpi_pkg::ST_TAKE;
      end
      wpi_pkg::ST_TAKE: begin
        cmd_o.take_last = 1'b1;
        state_d         = wpi_pkg::ST_EMIT;
      end
      wpi_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = wpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wpi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/wpi_datapath.sv
// Datapath of the waypoint pose interpolator: waypoint memories, segment scan,
// serial alpha divider, shared interpolation multiplier and the output register.
// Depends on wpi_pkg; driven by the command bundle from wpi_ctrl.
module wpi_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpi_pkg::wpi_cmd_t   cmd_i,
  output wpi_pkg::wpi_sts_t   sts_o,
  input  logic                first_point_i,
  input  logic         [31:0] time_value_i,
  input  wpi_pkg::wpi_point_t point_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output wpi_pkg::wpi_res_t   res_o
);

  localparam int IDX_W     = wpi_pkg::IDX_W;
  localparam int CNT_W     = wpi_pkg::CNT_W;
  localparam int ALPHA_W   = wpi_pkg::ALPHA_W;
  localparam int DIV_CNT_W = wpi_pkg::DIV_CNT_W;
  localparam int AX_W      = wpi_pkg::AX_W;
  localparam int PROD_W    = ALPHA_W + 1 + 33;

  localparam logic [AX_W-1:0] AX_X = AX_W'(0);
  localparam logic [AX_W-1:0] AX_Y = AX_W'(1);
  localparam logic [AX_W-1:0] AX_Z = AX_W'(2);

  // Waypoint memories
  logic [31:0] stamp_mem [wpi_pkg::MAX_POINTS];
  logic [31:0] x_mem     [wpi_pkg::MAX_POINTS];
  logic [31:0] y_mem     [wpi_pkg::MAX_POINTS];
  logic [31:0] z_mem     [wpi_pkg::MAX_POINTS];
  logic [63:0] quat_mem  [wpi_pkg::MAX_POINTS];

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] wr_pos;
  logic [CNT_W-1:0] last_pos;
  logic [IDX_W-1:0] last_idx;
  logic             wr_en;

  // Scan state
  logic [31:0]      t_q;
  logic [IDX_W-1:0] scan_idx_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             chk_vld_q;
  logic [31:0]      stamp_rd_q;
  logic [31:0]      prev_q;
  logic [IDX_W-1:0] seg0_q, seg1_q;
  logic             hit, miss;

  // Divider state
  logic [32:0]          div_rem_q;
  logic [31:0]          div_den_q;
  logic [ALPHA_W-1:0]   alpha_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 div_ge;
  logic [32:0]          div_sub;
  logic                 div_done;

  // Point read port and interpolation
  logic [IDX_W-1:0]        pt_addr;
  logic [31:0]             rd_x_q, rd_y_q, rd_z_q;
  logic [63:0]             rd_quat_q;
  logic [2:0][31:0]        p0_q;
  logic [AX_W-1:0]         ax_q;
  logic [31:0]             p0_sel, p1_sel;
  logic signed [32:0]      diff;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [31:0]             lerp_sum;

  wpi_pkg::wpi_res_t res_q, out_q;
  logic              out_valid_q;

  // Loads
  assign wr_pos   = first_point_i ? '0 : count_q;
  assign wr_en    = cmd_i.load && (first_point_i || (count_q < CNT_W'(wpi_pkg::MAX_POINTS)));
  assign last_pos = count_q - CNT_W'(1);
  assign last_idx = last_pos[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[wr_pos[IDX_W-1:0]] <= time_value_i;
      x_mem[wr_pos[IDX_W-1:0]]     <= point_i.x;
      y_mem[wr_pos[IDX_W-1:0]]     <= point_i.y;
      z_mem[wr_pos[IDX_W-1:0]]     <= point_i.z;
      quat_mem[wr_pos[IDX_W-1:0]]  <= {point_i.qw, point_i.qx, point_i.qy, point_i.qz};
    end
  end

  // Segment test: the checked entry closes the segment that the previous one opens.
  assign hit  = chk_vld_q && (chk_idx_q != '0) && (prev_q <= t_q) && (t_q <= stamp_rd_q);
  assign miss = chk_vld_q && (chk_idx_q == last_idx) && !hit;

  // Restoring division, one quotient bit a step.
  assign div_ge   = div_rem_q >= {1'b0, div_den_q};
  assign div_sub  = div_ge ? (div_rem_q - {1'b0, div_den_q}) : div_rem_q;
  assign div_done = (div_den_q == '0) || (div_cnt_q == DIV_CNT_W'(ALPHA_W));

  always_comb begin
    unique case (cmd_i.pt_rd_sel)
      wpi_pkg::RD_SEG0: pt_addr = seg0_q;
      wpi_pkg::RD_SEG1: pt_addr = seg1_q;
      wpi_pkg::RD_LAST: pt_addr = last_idx;
      default:          pt_addr = last_idx;
    endcase
  end

  always_comb begin
    p0_sel = p0_q[0];
    p1_sel = rd_x_q;
    case (ax_q)
      AX_X: begin
        p0_sel = p0_q[0];
        p1_sel = rd_x_q;
      end
      AX_Y: begin
        p0_sel = p0_q[1];
        p1_sel = rd_y_q;
      end
      AX_Z: begin
        p0_sel = p0_q[2];
        p1_sel = rd_z_q;
      end
      default: begin
        p0_sel = p0_q[0];
        p1_sel = rd_x_q;
      end
    endcase
  end

  assign diff   = $signed({p1_sel[31], p1_sel}) - $signed({p0_sel[31], p0_sel});
  assign prod_d = PROD_W'($signed({1'b0, alpha_q}) * diff);
  // The arithmetic shift by 16 floors; only the low 32 bits of the sum are kept.
  assign lerp_sum = p0_sel + prod_q[47:16];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      chk_vld_q   <= 1'b0;
      div_cnt_q   <= '0;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        count_q <= wr_pos + CNT_W'(1);
      end
      if (cmd_i.query_start) begin
        chk_vld_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        chk_vld_q <= 1'b1;
      end
      if (cmd_i.scan_run && hit) begin
        div_cnt_q <= '0;
        ax_q      <= '0;
      end else begin
        if (cmd_i.div_step && !div_done) begin
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
        end
        if (cmd_i.add) begin
          ax_q <= ax_q + AX_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      t_q        <= time_value_i;
      scan_idx_q <= '0;
    end
    if (cmd_i.scan_run) begin
      stamp_rd_q <= stamp_mem[scan_idx_q];
      chk_idx_q  <= scan_idx_q;
      if (scan_idx_q != last_idx) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (chk_vld_q) begin
        prev_q <= stamp_rd_q;
      end
      if (hit) begin
        seg0_q    <= chk_idx_q - IDX_W'(1);
        seg1_q    <= chk_idx_q;
        div_rem_q <= {1'b0, t_q - prev_q};
        div_den_q <= stamp_rd_q - prev_q;
        alpha_q   <= '0;
      end
    end
    if (cmd_i.div_step && !div_done) begin
      div_rem_q <= {div_sub[31:0], 1'b0};
      alpha_q   <= {alpha_q[ALPHA_W-2:0], div_ge};
    end
    if (cmd_i.pt_rd_en) begin
      rd_x_q    <= x_mem[pt_addr];
      rd_y_q    <= y_mem[pt_addr];
      rd_z_q    <= z_mem[pt_addr];
      rd_quat_q <= quat_mem[pt_addr];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end

    if (cmd_i.res_zero) begin
      res_q <= '0;
    end
    if (cmd_i.latch_p0) begin
      p0_q                <= {rd_z_q, rd_y_q, rd_x_q};
      res_q.pose_valid    <= 1'b1;
      res_q.point.qw      <= rd_quat_q[63:48];
      res_q.point.qx      <= rd_quat_q[47:32];
      res_q.point.qy      <= rd_quat_q[31:16];
      res_q.point.qz      <= rd_quat_q[15:0];
    end
    if (cmd_i.add) begin
      case (ax_q)
        AX_X:    res_q.point.x <= lerp_sum;
        AX_Y:    res_q.point.y <= lerp_sum;
        AX_Z:    res_q.point.z <= lerp_sum;
        default: res_q.point.x <= lerp_sum;
      endcase
    end
    if (cmd_i.take_last) begin
      res_q.pose_valid <= 1'b1;
      res_q.point.x    <= rd_x_q;
      res_q.point.y    <= rd_y_q;
      res_q.point.z    <= rd_z_q;
      res_q.point.qw   <= rd_quat_q[63:48];
      res_q.point.qx   <= rd_quat_q[47:32];
      res_q.point.qy   <= rd_quat_q[31:16];
      res_q.point.qz   <= rd_quat_q[15:0];
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.hit        = hit;
  assign sts_o.miss       = miss;
  assign sts_o.div_done   = div_done;
  assign sts_o.ax_last    = (ax_q == AX_Z);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

### hw/rtl/waypoint_pose_interpolator.sv
// Waypoint pose interpolator, top level: joins the controller and the datapath
// to the input and result channels. Depends on wpi_pkg, wpi_in_if and wpi_out_if.
//
// A load transaction writes one timestamped waypoint and returns no result;
// with first_point set it empties the table first, and once the table holds
// wpi_pkg::MAX_POINTS waypoints further loads without first_point are dropped.
// A query transaction returns exactly one pose. The stamp memory is scanned
// one entry a cycle until the first segment whose stamps enclose the query
// time; a serial restoring divider then produces alpha at one bit a cycle,
// the segment end points are read in turn, and one shared multiplier
// interpolates x, y and z in turn, each through a multiply and an add step.
// A query that falls outside every segment returns the last waypoint, and a
// query on an empty table gives pose_valid low and zeros elsewhere. The
// orientation is copied from the earlier point of the segment. Results sit in
// an output register, so one pose may wait for the consumer while the next
// transaction is taken; the block is busy with one query at a time and raises
// ready only when idle.
module waypoint_pose_interpolator (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpi_in_if.sink    in_i,
  wpi_out_if.source out_o
);

  wpi_pkg::wpi_cmd_t   cmd;
  wpi_pkg::wpi_sts_t   sts;
  wpi_pkg::wpi_point_t in_point;
  wpi_pkg::wpi_res_t   res;
  logic                out_valid;

  assign in_point.x  = in_i.pos_x;
  assign in_point.y  = in_i.pos_y;
  assign in_point.z  = in_i.pos_z;
  assign in_point.qw = in_i.quat_w;
  assign in_point.qx = in_i.quat_x;
  assign in_point.qy = in_i.quat_y;
  assign in_point.qz = in_i.quat_z;

  wpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (wpi_pkg::wpi_action_e'(in_i.action)),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wpi_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .first_point_i (in_i.first_point),
    .time_value_i  (in_i.time_value),
    .point_i       (in_point),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .res_o         (res)
  );

  // Result transaction
  assign out_o.valid      = out_valid;
  assign out_o.pose_valid = res.pose_valid;
  assign out_o.out_x      = res.point.x;
  assign out_o.out_y      = res.point.y;
  assign out_o.out_z      = res.point.z;
  assign out_o.out_qw     = res.point.qw;
  assign out_o.out_qx     = res.point.qx;
  assign out_o.out_qy     = res.point.qy;
  assign out_o.out_qz     = res.point.qz;

endmodule
